/* hdl/tgst_pkg.sv */
// shared constants, register indexes and state type for the two gate speed trap
`default_nettype none

package tgst_pkg;

    // field widths
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SPEED_W = 14;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;

    // divider sizing: dividend is spacing * 360000, divisor is dt <= 2000000
    localparam int unsigned NUM_W   = 35;
    localparam int unsigned DVS_W   = 21;
    localparam int unsigned CNT_W   = 6;

    // timing and scaling constants
    localparam logic [TIME_W-1:0]  TIMEOUT_US  = TIME_W'(2000000);
    localparam logic [TIME_W-1:0]  MIN_DT_US   = TIME_W'(50000);
    localparam logic [18:0]        CENTI_SCALE = 19'd360000;
    localparam logic [NUM_W-1:0]   MAX_CENTI   = NUM_W'(12000);
    localparam logic [NUM_W-1:0]   MIN_CENTI   = NUM_W'(200);

    // register reset values
    localparam logic [CFG_W-1:0] SPACING_RESET = CFG_W'(100);
    localparam logic [CFG_W-1:0] THRESH_RESET  = CFG_W'(30);

    // register indexes
    localparam logic [IDX_W-1:0] REG_SPACING = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_THRESH  = IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK
    } state_t;

endpackage

`default_nettype wire

/* hdl/two_gate_speed_trap_core.sv */
// top level of the two gate speed trap: arming, timeout and bit-serial speed divide
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------------
//  sample   | sample_valid/sample_stall| first_distance, second_distance, now_us
//  speed    | speed_valid/speed_stall  | speed_centi_kmh
//  cfg      | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// a sample that arms, disarms or is ignored leaves the core idle; a closing sample
// with dt in range runs a restoring divide of one quotient bit per cycle over the
// 35-bit dividend, then a check state, before the next sample is taken.
// an in-band result waits in check while a previous result is held and stalled.
// rst_n clears the arming state, the registers to their defaults and the output.
`default_nettype none

module two_gate_speed_trap_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // sample channel
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic [tgst_pkg::DIST_W-1:0]   first_distance,
    input  wire logic [tgst_pkg::DIST_W-1:0]   second_distance,
    input  wire logic [tgst_pkg::TIME_W-1:0]   now_us,
    // speed channel
    output logic                               speed_valid,
    input  wire logic                          speed_stall,
    output logic [tgst_pkg::SPEED_W-1:0]       speed_centi_kmh,
    // configuration channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tgst_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [tgst_pkg::CFG_W-1:0]    cfg_data
);

    tgst_pkg::state_t                  state_reg, state_next;
    logic                              armed_reg;
    logic [tgst_pkg::TIME_W-1:0]       start_reg;
    logic [tgst_pkg::CFG_W-1:0]        spacing_reg;
    logic [tgst_pkg::CFG_W-1:0]        thresh_reg;
    logic [tgst_pkg::NUM_W-1:0]        num_reg;
    logic [tgst_pkg::DVS_W-1:0]        dvs_reg;
    logic [tgst_pkg::DVS_W-1:0]        rem_reg;
    logic [tgst_pkg::CNT_W-1:0]        cnt_reg;
    logic                              out_valid_reg;
    logic [tgst_pkg::SPEED_W-1:0]      out_speed_reg;

    logic                              accept;
    logic [tgst_pkg::TIME_W-1:0]       dt;
    logic                              d1_ok, d2_ok;
    logic                              timed_out, closing, start_div;
    logic [tgst_pkg::DVS_W:0]          trial;
    logic                              qbit;
    logic [tgst_pkg::DVS_W-1:0]        rem_next;
    logic                              div_last;
    logic                              in_band;
    logic                              out_free;
    logic                              load_out;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // sample decode
    assign accept    = sample_valid && !sample_stall;
    assign dt        = now_us - start_reg;
    assign d1_ok     = (first_distance != '0) && (first_distance < thresh_reg);
    assign d2_ok     = (second_distance != '0) && (second_distance < thresh_reg);
    assign timed_out = armed_reg && (dt > tgst_pkg::TIMEOUT_US);
    assign closing   = armed_reg && !timed_out && d2_ok;
    assign start_div = accept && closing && (dt >= tgst_pkg::MIN_DT_US);

    // one restoring divide step
    assign trial    = {rem_reg, num_reg[tgst_pkg::NUM_W-1]};
    assign qbit     = trial >= {1'b0, dvs_reg};
    assign rem_next = qbit ? tgst_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                           : trial[tgst_pkg::DVS_W-1:0];
    assign div_last = cnt_reg == tgst_pkg::CNT_W'(tgst_pkg::NUM_W - 1);

    // speed band check on quotient and remainder
    assign in_band = (num_reg >= tgst_pkg::MIN_CENTI) &&
                     ((num_reg < tgst_pkg::MAX_CENTI) ||
                      ((num_reg == tgst_pkg::MAX_CENTI) && (rem_reg == '0)));
    assign out_free = !out_valid_reg || !speed_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tgst_pkg::ST_IDLE:
            begin
                if (start_div)
                    state_next = tgst_pkg::ST_DIV;
            end
            tgst_pkg::ST_DIV:
            begin
                if (div_last)
                    state_next = tgst_pkg::ST_CHECK;
            end
            tgst_pkg::ST_CHECK:
            begin
                if (!in_band || out_free)
                    state_next = tgst_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tgst_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        sample_stall = 1'b1;
        load_out     = 1'b0;
        unique case (state_reg)
            tgst_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
            end
            tgst_pkg::ST_DIV:
            begin
                sample_stall = 1'b1;
            end
            tgst_pkg::ST_CHECK:
            begin
                load_out = in_band && out_free;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tgst_pkg::ST_IDLE;
            armed_reg   <= 1'b0;
            start_reg   <= '0;
            spacing_reg <= tgst_pkg::SPACING_RESET;
            thresh_reg  <= tgst_pkg::THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tgst_pkg::REG_SPACING: spacing_reg <= cfg_data;
                    tgst_pkg::REG_THRESH:  thresh_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // arming and disarming
            if (accept)
            begin
                if (!armed_reg)
                begin
                    if (d1_ok)
                    begin
                        armed_reg <= 1'b1;
                        start_reg <= now_us;
                    end
                end
                else if (timed_out || d2_ok)
                begin
                    armed_reg <= 1'b0;
                end
            end

            // output beat
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!speed_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (start_div)
        begin
            num_reg <= tgst_pkg::NUM_W'(spacing_reg) * tgst_pkg::NUM_W'(tgst_pkg::CENTI_SCALE);
            dvs_reg <= dt[tgst_pkg::DVS_W-1:0];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == tgst_pkg::ST_DIV)
        begin
            num_reg <= {num_reg[tgst_pkg::NUM_W-2:0], qbit};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + tgst_pkg::CNT_W'(1);
        end
        if (load_out)
            out_speed_reg <= num_reg[tgst_pkg::SPEED_W-1:0];
    end

    assign speed_valid     = out_valid_reg;
    assign speed_centi_kmh = out_speed_reg;

endmodule

`default_nettype wire
